### rtl/core/tcdc_pkg.sv
// Shared types, constants and helper functions for the touch click/drag classifier.
// Used by tcdc_step and touch_click_drag_classifier_core; depends on nothing else.
package tcdc_pkg;

    localparam int COORD_BITS = 12;
    localparam int HIST_DEPTH = 3;
    localparam int VOTE_BITS = 4;
    localparam int THR_BITS = 12;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [VOTE_BITS-1:0] VOTE_MAX = '1;

    localparam logic [THR_BITS-1:0] FAST_THR_RESET = 12'd5;
    localparam logic [THR_BITS-1:0] PRIOR_THR_RESET = 12'd3;
    localparam logic [VOTE_BITS-1:0] VOTE_LIMIT_RESET = 4'd5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_THR = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRIOR_THR = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOTE_LIMIT = 2'd2;

    localparam logic ACTION_PEN_DOWN = 1'b0;
    localparam logic ACTION_PEN_UP = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_CLICK = 2'd1,
        MODE_DRAG = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_PRESS = 2'd1,
        EV_DRAG = 2'd2
    } event_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] p;
    } sample_t;

    typedef sample_t [HIST_DEPTH-1:0] hist_t;

    typedef struct packed {
        logic [THR_BITS-1:0] fast_thr;
        logic [THR_BITS-1:0] prior_thr;
        logic [VOTE_BITS-1:0] vote_limit;
    } cfg_t;

    typedef struct packed {
        event_t kind;
        sample_t cur;
        sample_t prev;
    } result_t;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic step_exceeds(
        input sample_t a,
        input sample_t b,
        input logic [THR_BITS-1:0] thr
    );
        return (abs_diff(a.x, b.x) > thr) || (abs_diff(a.y, b.y) > thr);
    endfunction

endpackage

### rtl/core/tcdc_step.sv
// Combinational classifier step: next mode, votes, history and result for one item.
// Depends on tcdc_pkg.
module tcdc_step (
    input  logic                               action,
    input  tcdc_pkg::sample_t                  sample,
    input  tcdc_pkg::mode_t                    mode,
    input  logic [tcdc_pkg::VOTE_BITS-1:0]     votes,
    input  tcdc_pkg::hist_t                    hist,
    input  tcdc_pkg::cfg_t                     cfg,
    output tcdc_pkg::mode_t                    mode_next,
    output logic [tcdc_pkg::VOTE_BITS-1:0]     votes_next,
    output tcdc_pkg::hist_t                    hist_next,
    output tcdc_pkg::result_t                  result
);

    tcdc_pkg::sample_t h1_shift;
    tcdc_pkg::sample_t h2_shift;
    logic move_vote;
    logic [tcdc_pkg::VOTE_BITS-1:0] votes_inc;

    // The first sample of a touch fills the whole history.
    assign h1_shift = (mode == tcdc_pkg::MODE_IDLE) ? sample : hist[0];
    assign h2_shift = (mode == tcdc_pkg::MODE_IDLE) ? sample : hist[1];

    assign move_vote = (mode != tcdc_pkg::MODE_DRAG)
                    && tcdc_pkg::step_exceeds(sample, h1_shift, cfg.fast_thr)
                    && tcdc_pkg::step_exceeds(h1_shift, h2_shift, cfg.prior_thr);

    assign votes_inc = (votes == tcdc_pkg::VOTE_MAX) ? votes
                                                     : votes + tcdc_pkg::VOTE_BITS'(1);

    always_comb begin
        mode_next = mode;
        unique case (mode)
            tcdc_pkg::MODE_IDLE: begin
                if (action == tcdc_pkg::ACTION_PEN_DOWN) begin
                    mode_next = tcdc_pkg::MODE_CLICK;
                end
            end
            tcdc_pkg::MODE_CLICK: begin
                if (action == tcdc_pkg::ACTION_PEN_UP) begin
                    mode_next = tcdc_pkg::MODE_IDLE;
                end else if (move_vote && (votes_inc > cfg.vote_limit)) begin
                    mode_next = tcdc_pkg::MODE_DRAG;
                end
            end
            tcdc_pkg::MODE_DRAG: begin
                if (action == tcdc_pkg::ACTION_PEN_UP) begin
                    mode_next = tcdc_pkg::MODE_IDLE;
                end
            end
            default: begin
                mode_next = tcdc_pkg::MODE_IDLE;
            end
        endcase
    end

    always_comb begin
        result = '0;
        votes_next = votes;
        hist_next = hist;
        if (action == tcdc_pkg::ACTION_PEN_UP) begin
            votes_next = '0;
            if (mode == tcdc_pkg::MODE_CLICK) begin
                result.kind = tcdc_pkg::EV_PRESS;
                result.cur = hist[0];
            end
        end else begin
            hist_next[0] = sample;
            hist_next[1] = h1_shift;
            hist_next[2] = h2_shift;
            if (move_vote) begin
                votes_next = votes_inc;
            end else if (mode == tcdc_pkg::MODE_DRAG) begin
                result.kind = tcdc_pkg::EV_DRAG;
                result.cur = sample;
                result.prev = h1_shift;
            end
        end
    end

endmodule

### rtl/core/touch_click_drag_classifier_core.sv
// Top level of the touch click/drag classifier: handshakes, state and result registers.
// Depends on tcdc_pkg and tcdc_step.

// Every accepted item produces exactly one result item, which appears in the output
// register in the cycle after acceptance. An item is accepted in every cycle as long
// as the output register is empty or its item is taken in the same cycle, so the block
// sustains one item per cycle; the single output register and its ready is what sets
// that figure. Event kind 0 means no event and then all other result fields are zero.
// Configuration writes are always accepted and must only happen while the block is idle.
module touch_click_drag_classifier_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_action,
    input  logic [tcdc_pkg::COORD_BITS-1:0]       s_pos_x,
    input  logic [tcdc_pkg::COORD_BITS-1:0]       s_pos_y,
    input  logic [tcdc_pkg::COORD_BITS-1:0]       s_pressure,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_event_kind,
    output logic [tcdc_pkg::COORD_BITS-1:0]       m_cur_x,
    output logic [tcdc_pkg::COORD_BITS-1:0]       m_cur_y,
    output logic [tcdc_pkg::COORD_BITS-1:0]       m_cur_pressure,
    output logic [tcdc_pkg::COORD_BITS-1:0]       m_prev_x,
    output logic [tcdc_pkg::COORD_BITS-1:0]       m_prev_y,
    output logic [tcdc_pkg::COORD_BITS-1:0]       m_prev_pressure,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tcdc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [tcdc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    tcdc_pkg::mode_t mode_reg;
    tcdc_pkg::mode_t mode_next;
    logic [tcdc_pkg::VOTE_BITS-1:0] votes_reg;
    logic [tcdc_pkg::VOTE_BITS-1:0] votes_next;
    tcdc_pkg::hist_t hist_reg;
    tcdc_pkg::hist_t hist_next;
    tcdc_pkg::cfg_t cfg_reg;
    tcdc_pkg::result_t result_reg;
    tcdc_pkg::result_t result_next;
    logic m_valid_reg;
    tcdc_pkg::sample_t in_sample;
    logic s_fire;

    assign in_sample.x = s_pos_x;
    assign in_sample.y = s_pos_y;
    assign in_sample.p = s_pressure;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    tcdc_step u_step (
        .action     (s_action),
        .sample     (in_sample),
        .mode       (mode_reg),
        .votes      (votes_reg),
        .hist       (hist_reg),
        .cfg        (cfg_reg),
        .mode_next  (mode_next),
        .votes_next (votes_next),
        .hist_next  (hist_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= tcdc_pkg::MODE_IDLE;
            votes_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                mode_reg <= mode_next;
                votes_reg <= votes_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hist_reg <= hist_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_thr <= tcdc_pkg::FAST_THR_RESET;
            cfg_reg.prior_thr <= tcdc_pkg::PRIOR_THR_RESET;
            cfg_reg.vote_limit <= tcdc_pkg::VOTE_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tcdc_pkg::REG_FAST_THR: begin
                    cfg_reg.fast_thr <= cfg_data[tcdc_pkg::THR_BITS-1:0];
                end
                tcdc_pkg::REG_PRIOR_THR: begin
                    cfg_reg.prior_thr <= cfg_data[tcdc_pkg::THR_BITS-1:0];
                end
                tcdc_pkg::REG_VOTE_LIMIT: begin
                    cfg_reg.vote_limit <= cfg_data[tcdc_pkg::VOTE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_event_kind = result_reg.kind;
    assign m_cur_x = result_reg.cur.x;
    assign m_cur_y = result_reg.cur.y;
    assign m_cur_pressure = result_reg.cur.p;
    assign m_prev_x = result_reg.prev.x;
    assign m_prev_y = result_reg.prev.y;
    assign m_prev_pressure = result_reg.prev.p;

`ifndef SYNTHESIS
    // A pen-up always leaves the block idle with no votes.
    a_pen_up_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_action) |=> (mode_reg == tcdc_pkg::MODE_IDLE) && (votes_reg == '0))
        else $error("pen-up did not return to idle with cleared votes");

    // A sample taken in drag mode always produces a drag item.
    a_drag_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_action && (mode_reg == tcdc_pkg::MODE_DRAG))
        |=> m_valid && (m_event_kind == tcdc_pkg::EV_DRAG))
        else $error("sample in drag mode did not produce a drag item");

    // The first sample of a touch enters click mode and fills the whole history.
    a_first_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_action && (mode_reg == tcdc_pkg::MODE_IDLE))
        |=> (mode_reg == tcdc_pkg::MODE_CLICK) && (hist_reg[0] == hist_reg[1])
            && (hist_reg[1] == hist_reg[2]))
        else $error("first sample did not fill the history");

    // The input side is open whenever the output register is empty.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with an empty output register");
`endif

endmodule
